/* hdl/xmov_pkg.sv */
// ---------------------------------------------------------------------------
// xmov_pkg
// Shared types and codes of the MOV instruction field decoder.
// ---------------------------------------------------------------------------
package xmov_pkg;

	localparam logic [5:0] OPC_MOV_RM  = 6'd34;
	localparam logic [3:0] OPC_MOV_IMM = 4'd11;
	localparam logic [2:0] RM_DIRECT   = 3'd6;

	localparam logic [1:0] KIND_MOV_RM  = 2'd0;
	localparam logic [1:0] KIND_MOV_IMM = 2'd1;
	localparam logic [1:0] KIND_ERROR   = 2'd2;

	localparam int QDEPTH = 4;
	localparam int QAW    = 2;

	typedef enum logic [2:0] {
		TAG_OPCODE,
		TAG_MODRM,
		TAG_DATA_LO,
		TAG_DATA_HI,
		TAG_ERROR
	} tag_t;

	typedef struct packed {
		logic [7:0] code;
		tag_t       tag;
		logic       last;
	} entry_t;

	typedef struct packed {
		logic [1:0]  instr_kind;
		logic        to_reg;
		logic        word_op;
		logic [1:0]  mode;
		logic [2:0]  reg_index;
		logic [2:0]  rm_index;
		logic        direct_address;
		logic [15:0] displacement;
		logic [15:0] immediate;
		logic [2:0]  length;
	} result_t;

endpackage

/* hdl/x86_mov_instruction_field_decoder_top.sv */
// ---------------------------------------------------------------------------
// x86_mov_instruction_field_decoder_top
// Decodes MOV reg/mem and MOV immediate instructions from a code byte stream.
//
//   channel  direction  tdata                   tuser
//   s_axis   in         code_byte               -
//   m_axis   out        decoded fields, length  instr_kind
//
// One byte is taken per cycle; the front tags each byte by instruction phase
// and a four-entry queue feeds the back. The back raises m_tvalid at the edge
// where the last byte of an instruction leaves the queue, into which that
// byte is written when taken. A stalled output fills the queue, after which
// s_tready drops. Reset is asynchronous and needs no clearing pass. After an
// unknown opcode the block drops all bytes until reset.
// ---------------------------------------------------------------------------
module x86_mov_instruction_field_decoder_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] code_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [0] to_reg, [1] word_op, [3:2] mode, [6:4] reg_index,
	                               // [9:7] rm_index, [10] direct_address,
	                               // [26:11] displacement, [42:27] immediate,
	                               // [45:43] length, [47:46] zero
	output logic [1:0]  m_tuser    // [1:0] instr_kind
);
	import xmov_pkg::*;

	logic    push, q_ready, pop, q_valid;
	entry_t  push_entry, pop_entry;
	result_t res;

	xmov_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_code    (s_tdata),
		.push       (push),
		.push_entry (push_entry),
		.q_ready    (q_ready)
	);

	xmov_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.push_ready (q_ready),
		.pop        (pop),
		.pop_valid  (q_valid),
		.pop_entry  (pop_entry)
	);

	xmov_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_entry    (pop_entry),
		.pop        (pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_result (res)
	);

	assign m_tuser = res.instr_kind;
	assign m_tdata = {2'b00, res.length, res.immediate, res.displacement,
	                  res.direct_address, res.rm_index, res.reg_index, res.mode,
	                  res.word_op, res.to_reg};

endmodule

/* hdl/xmov_front.sv */
// ---------------------------------------------------------------------------
// xmov_front
// Accepts code bytes, tracks the instruction phase and tags each byte.
// ---------------------------------------------------------------------------
module xmov_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [7:0]       in_code,
	output logic             push,
	output xmov_pkg::entry_t push_entry,
	input  logic             q_ready
);
	import xmov_pkg::*;

	localparam logic [1:0] PH_OPCODE  = 2'd0;
	localparam logic [1:0] PH_MODRM   = 2'd1;
	localparam logic [1:0] PH_DATA_LO = 2'd2;
	localparam logic [1:0] PH_DATA_HI = 2'd3;

	logic [1:0] phase_q, phase_d;
	logic [1:0] left_q, left_d;
	logic       halted_q, halted_d;
	logic [1:0] n_disp;

	assign in_ready = halted_q || q_ready;
	assign push     = in_valid && q_ready && !halted_q;

	always_comb begin
		unique case (in_code[7:6])
			2'd0:    n_disp = (in_code[2:0] == RM_DIRECT) ? 2'd2 : 2'd0;
			2'd1:    n_disp = 2'd1;
			2'd2:    n_disp = 2'd2;
			default: n_disp = 2'd0;
		endcase
	end

	always_comb begin
		phase_d         = phase_q;
		left_d          = left_q;
		halted_d        = halted_q;
		push_entry.code = in_code;
		push_entry.tag  = TAG_OPCODE;
		push_entry.last = 1'b0;
		unique case (phase_q)
			PH_OPCODE: begin
				if (in_code[7:4] == OPC_MOV_IMM) begin
					left_d  = in_code[3] ? 2'd2 : 2'd1;
					phase_d = PH_DATA_LO;
				end else if (in_code[7:2] == OPC_MOV_RM) begin
					left_d  = 2'd0;
					phase_d = PH_MODRM;
				end else begin
					push_entry.tag  = TAG_ERROR;
					push_entry.last = 1'b1;
					halted_d        = 1'b1;
					left_d          = 2'd0;
				end
			end
			PH_MODRM: begin
				push_entry.tag = TAG_MODRM;
				if (n_disp == 2'd0) begin
					push_entry.last = 1'b1;
					phase_d         = PH_OPCODE;
				end else begin
					left_d  = n_disp;
					phase_d = PH_DATA_LO;
				end
			end
			PH_DATA_LO: begin
				push_entry.tag = TAG_DATA_LO;
				if (left_q == 2'd2) begin
					phase_d = PH_DATA_HI;
				end else begin
					push_entry.last = 1'b1;
					phase_d         = PH_OPCODE;
					left_d          = 2'd0;
				end
			end
			default: begin
				push_entry.tag  = TAG_DATA_HI;
				push_entry.last = 1'b1;
				phase_d         = PH_OPCODE;
				left_d          = 2'd0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_OPCODE;
			left_q   <= 2'd0;
			halted_q <= 1'b0;
		end else if (push) begin
			phase_q  <= phase_d;
			left_q   <= left_d;
			halted_q <= halted_d;
		end
	end

endmodule

/* hdl/xmov_queue.sv */
// ---------------------------------------------------------------------------
// xmov_queue
// Short FIFO of tagged bytes between the front and the back.
// ---------------------------------------------------------------------------
module xmov_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  xmov_pkg::entry_t push_entry,
	output logic             push_ready,
	input  logic             pop,
	output logic             pop_valid,
	output xmov_pkg::entry_t pop_entry
);
	import xmov_pkg::*;

	entry_t         slot_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QAW:0]   count_q;
	logic           do_push, do_pop;

	assign push_ready = (count_q != QDEPTH[QAW:0]);
	assign pop_valid  = (count_q != '0);
	assign pop_entry  = slot_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* hdl/xmov_back.sv */
// ---------------------------------------------------------------------------
// xmov_back
// Assembles tagged bytes into decoded results and holds the output beat.
// ---------------------------------------------------------------------------
module xmov_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  xmov_pkg::entry_t  q_entry,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output xmov_pkg::result_t out_result
);
	import xmov_pkg::*;

	logic [7:0]  first_q, modrm_q, low_q;
	logic [2:0]  count_q, count_d;
	logic        valid_q;
	result_t     res_q, res_d;
	logic [7:0]  modrm;
	logic [15:0] value;

	assign pop        = q_valid && (!valid_q || out_ready);
	assign out_valid  = valid_q;
	assign out_result = res_q;

	always_comb begin
		modrm   = (q_entry.tag == TAG_MODRM) ? q_entry.code : modrm_q;
		count_d = count_q + 3'd1;
		value   = 16'd0;
		unique case (q_entry.tag)
			TAG_MODRM:   count_d = 3'd2;
			TAG_DATA_LO: value   = {{8{q_entry.code[7]}}, q_entry.code};
			TAG_DATA_HI: value   = {q_entry.code, low_q};
			default:     count_d = 3'd1;
		endcase

		res_d = '0;
		if (q_entry.tag == TAG_ERROR) begin
			res_d.instr_kind = KIND_ERROR;
			res_d.length     = 3'd1;
		end else if (first_q[7:4] == OPC_MOV_IMM) begin
			res_d.instr_kind = KIND_MOV_IMM;
			res_d.to_reg     = 1'b1;
			res_d.word_op    = first_q[3];
			res_d.reg_index  = first_q[2:0];
			res_d.immediate  = value;
			res_d.length     = count_d;
		end else begin
			res_d.instr_kind     = KIND_MOV_RM;
			res_d.to_reg         = first_q[1];
			res_d.word_op        = first_q[0];
			res_d.mode           = modrm[7:6];
			res_d.reg_index      = modrm[5:3];
			res_d.rm_index       = modrm[2:0];
			res_d.direct_address = (modrm[7:6] == 2'd0) && (modrm[2:0] == RM_DIRECT);
			res_d.displacement   = value;
			res_d.length         = count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && q_entry.last) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			first_q <= 8'd0;
			modrm_q <= 8'd0;
			low_q   <= 8'd0;
			count_q <= 3'd0;
		end else begin
			if (pop && q_entry.last) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
			if (pop) begin
				count_q <= count_d;
				case (q_entry.tag)
					TAG_OPCODE: begin
						first_q <= q_entry.code;
						modrm_q <= 8'd0;
						low_q   <= 8'd0;
					end
					TAG_MODRM: begin
						modrm_q <= q_entry.code;
					end
					TAG_DATA_LO: begin
						low_q <= q_entry.code;
					end
					default: begin
					end
				endcase
			end
		end
	end

endmodule

/* test/x86_mov_instruction_field_decoder_top_tb.sv */
// ---------------------------------------------------------------------------
// x86_mov_instruction_field_decoder_top_tb
// Streams MOV reg/mem and MOV immediate instructions into the decoder with
// random gaps and output stalls. Every decoded beat is checked against an
// in-bench decoder. The run ends with an unknown opcode, after which the
// block must stay silent.
// ---------------------------------------------------------------------------
module x86_mov_instruction_field_decoder_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import xmov_pkg::*;

	localparam int RANDOM_BYTES = 1900;
	localparam int IDLE_LIMIT   = 2000;
	localparam int TAIL_CYCLES  = 12;

	typedef enum logic [1:0] {
		STAGE_OPCODE,
		STAGE_MODRM,
		STAGE_DATA_LO,
		STAGE_DATA_HI
	} stage_t;

	class mov_scoreboard;
		result_t    expected_results[$];
		int         failures = 0;
		stage_t     stage = STAGE_OPCODE;
		logic [7:0] opcode_q = '0;
		logic [7:0] modrm_q = '0;
		logic [1:0] data_needed = '0;
		logic [7:0] lo_q = '0;
		logic [2:0] count_q = '0;
		logic       stopped = 1'b0;

		function automatic int pending();
			return expected_results.size();
		endfunction

		function automatic result_t finish_instr(input logic [15:0] value);
			result_t r;
			r = '0;
			if (opcode_q[7:4] == OPC_MOV_IMM) begin
				r.instr_kind = KIND_MOV_IMM;
				r.to_reg     = 1'b1;
				r.word_op    = opcode_q[3];
				r.reg_index  = opcode_q[2:0];
				r.immediate  = value;
			end else begin
				r.instr_kind     = KIND_MOV_RM;
				r.to_reg         = opcode_q[1];
				r.word_op        = opcode_q[0];
				r.mode           = modrm_q[7:6];
				r.reg_index      = modrm_q[5:3];
				r.rm_index       = modrm_q[2:0];
				r.direct_address = (modrm_q[7:6] == 2'd0) && (modrm_q[2:0] == RM_DIRECT);
				r.displacement   = value;
			end
			r.length    = count_q;
			stage       = STAGE_OPCODE;
			data_needed = '0;
			return r;
		endfunction

		function automatic void note_byte(input logic [7:0] b);
			result_t r;
			if (stopped)
				return;
			case (stage)
			STAGE_MODRM: begin
				modrm_q = b;
				count_q = 3'd2;
				if (b[7:6] == 2'd1)
					data_needed = 2'd1;
				else if (b[7:6] == 2'd2 || (b[7:6] == 2'd0 && b[2:0] == RM_DIRECT))
					data_needed = 2'd2;
				else
					data_needed = 2'd0;
				if (data_needed == 2'd0)
					expected_results.push_back(finish_instr(16'h0000));
				else
					stage = STAGE_DATA_LO;
			end
			STAGE_DATA_LO: begin
				count_q = count_q + 3'd1;
				if (data_needed == 2'd2) begin
					lo_q  = b;
					stage = STAGE_DATA_HI;
				end else begin
					expected_results.push_back(finish_instr({{8{b[7]}}, b}));
				end
			end
			STAGE_DATA_HI: begin
				count_q = count_q + 3'd1;
				expected_results.push_back(finish_instr({b, lo_q}));
			end
			default: begin
				opcode_q = b;
				modrm_q  = '0;
				lo_q     = '0;
				count_q  = 3'd1;
				if (b[7:4] == OPC_MOV_IMM) begin
					data_needed = b[3] ? 2'd2 : 2'd1;
					stage       = STAGE_DATA_LO;
				end else if (b[7:2] == OPC_MOV_RM) begin
					data_needed = 2'd0;
					stage       = STAGE_MODRM;
				end else begin
					r            = '0;
					r.instr_kind = KIND_ERROR;
					r.length     = 3'd1;
					stopped      = 1'b1;
					stage        = STAGE_OPCODE;
					data_needed  = '0;
					expected_results.push_back(r);
				end
			end
			endcase
		endfunction

		function automatic void compare(input string name, input int want, input int got);
			if (want != got) begin
				$error("%s: expected %0h actual %0h", name, want, got);
				failures++;
			end
		endfunction

		function automatic void check_result(input logic [1:0] kind, input logic [47:0] d);
			result_t e;
			if (expected_results.size() == 0) begin
				$error("unexpected result beat: kind %0d data %0h", kind, d);
				failures++;
				return;
			end
			e = expected_results.pop_front();
			compare("instr_kind", int'(e.instr_kind), int'(kind));
			compare("to_reg", int'(e.to_reg), int'(d[0]));
			compare("word_op", int'(e.word_op), int'(d[1]));
			compare("mode", int'(e.mode), int'(d[3:2]));
			compare("reg_index", int'(e.reg_index), int'(d[6:4]));
			compare("rm_index", int'(e.rm_index), int'(d[9:7]));
			compare("direct_address", int'(e.direct_address), int'(d[10]));
			compare("displacement", int'(e.displacement), int'(d[26:11]));
			compare("immediate", int'(e.immediate), int'(d[42:27]));
			compare("length", int'(e.length), int'(d[45:43]));
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic [1:0]  m_tuser;

	mov_scoreboard decoder_sb = new();
	int            idle_cycles = 0;
	int            bytes_sent = 0;
	bit            fast_mode = 1'b0;
	bit            started = 1'b0;

	x86_mov_instruction_field_decoder_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			decoder_sb.check_result(m_tuser, m_tdata);
		if (s_tvalid && s_tready)
			decoder_sb.note_byte(s_tdata);
		if (!started || (m_tvalid && m_tready) || (s_tvalid && s_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		while (idle_cycles < IDLE_LIMIT)
			@(posedge clk);
		$display("x86_mov_instruction_field_decoder_top_tb: FAIL");
		$finish;
	end

	initial begin
		int stall;
		wait (started);
		forever begin
			stall = fast_mode ? 0 : $urandom_range(0, 3);
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid)
				@(posedge clk);
		end
	end

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = fast_mode ? 0 : $urandom_range(0, 3);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		bytes_sent++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (decoder_sb.pending() != 0)
			@(posedge clk);
	endtask

	function automatic logic [7:0] data_byte();
		case ($urandom_range(0, 11))
		0: return 8'h00;
		1: return 8'hFF;
		2: return 8'h80;
		3: return 8'h7F;
		default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic send_random_instr();
		logic [7:0] op;
		logic [7:0] modrm;
		int         extra;
		if ($urandom_range(0, 1) == 1) begin
			op      = {OPC_MOV_IMM, 4'b0000};
			op[3:0] = 4'($urandom_range(0, 15));
			send_byte(op);
			send_byte(data_byte());
			if (op[3])
				send_byte(data_byte());
		end else begin
			op      = {OPC_MOV_RM, 2'b00};
			op[1:0] = 2'($urandom_range(0, 3));
			modrm   = 8'($urandom_range(0, 255));
			if ($urandom_range(0, 7) == 0)
				modrm = {2'b00, modrm[5:3], RM_DIRECT};
			if (modrm[7:6] == 2'd1)
				extra = 1;
			else if (modrm[7:6] == 2'd2 || (modrm[7:6] == 2'd0 && modrm[2:0] == RM_DIRECT))
				extra = 2;
			else
				extra = 0;
			send_byte(op);
			send_byte(modrm);
			repeat (extra) send_byte(data_byte());
		end
	endtask

	initial begin
		logic [7:0] directed[] = '{
			8'h88, 8'hC0,
			8'h8B, 8'hFF,
			8'h89, 8'h3E, 8'h34, 8'h12,
			8'h8A, 8'h47, 8'h80,
			8'h8B, 8'hBF, 8'hFF, 8'h7F,
			8'h88, 8'h00,
			8'hB0, 8'h7F,
			8'hBF, 8'h00, 8'h80,
			8'hB8, 8'hFF, 8'hFF
		};
		logic [7:0] bad_op;
		int         random_start;

		repeat (2) @(posedge clk);
		arst_n  <= 1'b1;
		started = 1'b1;
		@(posedge clk);

		foreach (directed[i])
			send_byte(directed[i]);
		drain();

		random_start = bytes_sent;
		while (bytes_sent - random_start < RANDOM_BYTES) begin
			fast_mode = (bytes_sent - random_start > 600) && (bytes_sent - random_start < 900);
			send_random_instr();
			if (bytes_sent - random_start > RANDOM_BYTES / 2 && bytes_sent - random_start < RANDOM_BYTES / 2 + 5)
				drain();
		end
		fast_mode = 1'b0;
		drain();

		// unknown opcode halts the block; the trailing beats must be dropped
		do
			bad_op = 8'($urandom_range(0, 255));
		while (bad_op[7:4] == OPC_MOV_IMM || bad_op[7:2] == OPC_MOV_RM);
		send_byte(bad_op);
		repeat (8) send_byte(data_byte());
		drain();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (decoder_sb.failures == 0 && decoder_sb.pending() == 0)
			$display("x86_mov_instruction_field_decoder_top_tb: PASS");
		else
			$display("x86_mov_instruction_field_decoder_top_tb: FAIL");
		$finish;
	end

endmodule
